[design/gft_pkg.sv]
// Shared types, constants and arithmetic helpers for the gait foot trajectory block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package gft_pkg;

    localparam int NUM_LEGS  = 4;
    localparam int POS_W     = 36;
    localparam int FRAC_BITS = 17;

    localparam logic [1:0] GAIT_TROT   = 2'd0;
    localparam logic [1:0] GAIT_CRAWL  = 2'd1;
    localparam logic [1:0] GAIT_GALLOP = 2'd2;

    localparam logic [1:0] REG_GAIT_TYPE   = 2'd0;
    localparam logic [1:0] REG_CURVE_DELTA = 2'd1;

    localparam logic [1:0]  GAIT_TYPE_RST   = GAIT_TROT;
    localparam logic [15:0] CURVE_DELTA_RST = 16'd13107;

    // ceil(2^19 / 3): floor(x / 3) == (x * DIV3_RECIP) >> 19 for every x below 2^19.
    localparam logic [17:0] DIV3_RECIP = 18'd174763;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [1:0]         leg;
        logic [15:0]        phase;
        logic signed [15:0] step_x;
        logic signed [15:0] step_z;
        logic [14:0]        lift_height;
        logic signed [15:0] neutral_x;
        logic signed [15:0] neutral_y;
        logic signed [15:0] neutral_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] foot_x;
        logic signed [15:0] foot_y;
        logic signed [15:0] foot_z;
        logic               in_swing;
    } out_t;

    typedef struct packed {
        logic [5:0][POS_W-1:0] x;
        logic [5:0][POS_W-1:0] y;
        logic [5:0][POS_W-1:0] z;
    } cpts_t;

    function automatic logic [15:0] leg_offset(logic [1:0] gait, logic [1:0] leg);
        logic [15:0] off;
        case (gait)
            GAIT_CRAWL: begin
                case (leg)
                    2'd0:    off = 16'd0;
                    2'd1:    off = 16'd32768;
                    2'd2:    off = 16'd49152;
                    default: off = 16'd16384;
                endcase
            end
            GAIT_GALLOP: begin
                case (leg)
                    2'd0:    off = 16'd0;
                    2'd1:    off = 16'd8192;
                    2'd2:    off = 16'd40960;
                    default: off = 16'd32768;
                endcase
            end
            default: begin
                // The reserved gait code behaves as trot.
                off = leg[0] ? 16'd32768 : 16'd0;
            end
        endcase
        return off;
    endfunction

    // One de Casteljau step: a + floor(((b - a) * t + 2^15) / 2^16).
    function automatic pos_t lerp(pos_t a, pos_t b, logic [15:0] t);
        logic signed [POS_W:0]    diff;
        logic signed [POS_W+17:0] prod;
        logic signed [POS_W+17:0] rnd;
        diff = (POS_W+1)'(b) - (POS_W+1)'(a);
        prod = diff * $signed({1'b0, t});
        rnd  = (prod + (POS_W+18)'(32768)) >>> 16;
        return a + pos_t'(rnd[POS_W-1:0]);
    endfunction

    // Round to the output unit and saturate to 16 bits.
    function automatic logic [15:0] to_out(pos_t v);
        logic signed [POS_W:0] r;
        r = ((POS_W+1)'(v) + (POS_W+1)'(65536)) >>> FRAC_BITS;
        if (r > (POS_W+1)'(32767)) begin
            return 16'h7FFF;
        end else if (r < -(POS_W+1)'(32768)) begin
            return 16'h8000;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

[design/gft_front.sv]
// Front end: leg phase, swing test, curve parameter, stance position and control points.
// Four register stages; depends on gft_pkg.
`default_nettype none

module gft_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire gft_pkg::in_t  in_data,
    input  wire logic [1:0]    gait_type,
    input  wire logic [15:0]   curve_delta,
    output logic               out_valid,
    input  wire logic          out_ready,
    output gft_pkg::cpts_t     out_cpts,
    output logic [15:0]        out_t,
    output logic               out_swing
);

    logic [4:1] en;

    // Stage 1 signals.
    logic [15:0]    p_next;
    logic           crawl_next;
    logic           swing_next;
    logic [15:0]    t_next;
    logic [15:0]    q_next;
    logic [17:0]    ux_next;
    logic           s1_valid_reg;
    logic           s1_crawl_reg;
    logic           s1_swing_reg;
    logic [15:0]    s1_t_reg;
    logic [17:0]    s1_ux_reg;
    logic [15:0]    s1_delta_reg;
    gft_pkg::in_t   s1_data_reg;

    // Stage 2 signals.
    logic [35:0]        div_prod;
    logic [15:0]        u_next;
    logic signed [32:0] ox_next;
    logic signed [32:0] oz_next;
    logic               s2_valid_reg;
    logic               s2_crawl_reg;
    logic               s2_swing_reg;
    logic [15:0]        s2_t_reg;
    logic [15:0]        s2_u_reg;
    logic signed [32:0] s2_ox_reg;
    logic signed [32:0] s2_oz_reg;
    gft_pkg::in_t       s2_data_reg;

    // Stage 3 signals.
    logic signed [32:0] mx_next;
    logic signed [32:0] mz_next;
    logic               s3_valid_reg;
    logic               s3_swing_reg;
    logic [15:0]        s3_t_reg;
    logic signed [32:0] s3_ox_reg;
    logic signed [32:0] s3_oz_reg;
    logic signed [32:0] s3_mx_reg;
    logic signed [32:0] s3_mz_reg;
    gft_pkg::in_t       s3_data_reg;

    // Stage 4 signals.
    gft_pkg::pos_t  nxp, nyp, nzp, hxp, hzp, oxp, ozp, mxp, mzp, lfp;
    gft_pkg::pos_t  stance_x, stance_z;
    gft_pkg::cpts_t cpts_next;
    logic           s4_valid_reg;
    logic           s4_swing_reg;
    logic [15:0]    s4_t_reg;
    gft_pkg::cpts_t s4_cpts_reg;

    assign en[4]    = !s4_valid_reg || out_ready;
    assign en[3]    = !s3_valid_reg || en[4];
    assign en[2]    = !s2_valid_reg || en[3];
    assign en[1]    = !s1_valid_reg || en[2];
    assign in_ready = en[1];

    always_comb begin
        p_next     = in_data.phase + gft_pkg::leg_offset(gait_type, in_data.leg);
        crawl_next = (gait_type == gft_pkg::GAIT_CRAWL);
        swing_next = crawl_next ? (p_next[15:14] == 2'b00) : !p_next[15];
        t_next     = crawl_next ? {p_next[13:0], 2'b00} : {p_next[14:0], 1'b0};
        q_next     = p_next - 16'd16384;
        // Crawl stance needs (4q + 1) / 3; the other gaits get u directly.
        ux_next    = crawl_next ? {q_next, 2'b01} : {2'b00, t_next};
    end

    always_comb begin
        div_prod = s1_ux_reg * gft_pkg::DIV3_RECIP;
        u_next   = (s1_crawl_reg && !s1_swing_reg) ? div_prod[34:19] : s1_ux_reg[15:0];
        ox_next  = $signed(s1_data_reg.step_x) * $signed({1'b0, s1_delta_reg});
        oz_next  = $signed(s1_data_reg.step_z) * $signed({1'b0, s1_delta_reg});
    end

    always_comb begin
        mx_next = $signed(s2_data_reg.step_x) * $signed({1'b0, s2_u_reg});
        mz_next = $signed(s2_data_reg.step_z) * $signed({1'b0, s2_u_reg});
    end

    always_comb begin
        nxp = {{(gft_pkg::POS_W-33){s3_data_reg.neutral_x[15]}}, s3_data_reg.neutral_x, 17'b0};
        nyp = {{(gft_pkg::POS_W-33){s3_data_reg.neutral_y[15]}}, s3_data_reg.neutral_y, 17'b0};
        nzp = {{(gft_pkg::POS_W-33){s3_data_reg.neutral_z[15]}}, s3_data_reg.neutral_z, 17'b0};
        hxp = {{(gft_pkg::POS_W-32){s3_data_reg.step_x[15]}}, s3_data_reg.step_x, 16'b0};
        hzp = {{(gft_pkg::POS_W-32){s3_data_reg.step_z[15]}}, s3_data_reg.step_z, 16'b0};
        oxp = {{(gft_pkg::POS_W-34){s3_ox_reg[32]}}, s3_ox_reg, 1'b0};
        ozp = {{(gft_pkg::POS_W-34){s3_oz_reg[32]}}, s3_oz_reg, 1'b0};
        mxp = {{(gft_pkg::POS_W-34){s3_mx_reg[32]}}, s3_mx_reg, 1'b0};
        mzp = {{(gft_pkg::POS_W-34){s3_mz_reg[32]}}, s3_mz_reg, 1'b0};
        lfp = {{(gft_pkg::POS_W-32){1'b0}}, s3_data_reg.lift_height, 17'b0};
        stance_x = nxp + hxp - mxp;
        stance_z = nzp + hzp - mzp;
        if (s3_swing_reg) begin
            cpts_next.x[0] = nxp - hxp;
            cpts_next.x[1] = nxp - hxp - oxp;
            cpts_next.x[2] = nxp - hxp;
            cpts_next.x[3] = nxp + hxp;
            cpts_next.x[4] = nxp + hxp + oxp;
            cpts_next.x[5] = nxp + hxp;
            cpts_next.z[0] = nzp - hzp;
            cpts_next.z[1] = nzp - hzp - ozp;
            cpts_next.z[2] = nzp - hzp;
            cpts_next.z[3] = nzp + hzp;
            cpts_next.z[4] = nzp + hzp + ozp;
            cpts_next.z[5] = nzp + hzp;
            cpts_next.y[0] = nyp;
            cpts_next.y[1] = nyp;
            cpts_next.y[2] = nyp - lfp;
            cpts_next.y[3] = nyp - lfp;
            cpts_next.y[4] = nyp;
            cpts_next.y[5] = nyp;
        end else begin
            // With all six points equal, the arc stages pass the stance point through.
            for (int i = 0; i < 6; i++) begin
                cpts_next.x[i] = stance_x;
                cpts_next.y[i] = nyp;
                cpts_next.z[i] = stance_z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (en[1]) begin
                s1_valid_reg <= in_valid;
            end
            if (en[2]) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en[3]) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en[4]) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_crawl_reg <= crawl_next;
            s1_swing_reg <= swing_next;
            s1_t_reg     <= t_next;
            s1_ux_reg    <= ux_next;
            s1_delta_reg <= curve_delta;
            s1_data_reg  <= in_data;
        end
        if (en[2]) begin
            s2_crawl_reg <= s1_crawl_reg;
            s2_swing_reg <= s1_swing_reg;
            s2_t_reg     <= s1_t_reg;
            s2_u_reg     <= u_next;
            s2_ox_reg    <= ox_next;
            s2_oz_reg    <= oz_next;
            s2_data_reg  <= s1_data_reg;
        end
        if (en[3]) begin
            s3_swing_reg <= s2_swing_reg;
            s3_t_reg     <= s2_t_reg;
            s3_ox_reg    <= s2_ox_reg;
            s3_oz_reg    <= s2_oz_reg;
            s3_mx_reg    <= mx_next;
            s3_mz_reg    <= mz_next;
            s3_data_reg  <= s2_data_reg;
        end
        if (en[4]) begin
            s4_swing_reg <= s3_swing_reg;
            s4_t_reg     <= s3_t_reg;
            s4_cpts_reg  <= cpts_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_cpts  = s4_cpts_reg;
    assign out_t     = s4_t_reg;
    assign out_swing = s4_swing_reg;

    a_crawl_stance_num: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_crawl_reg && !s1_swing_reg) |-> (s1_ux_reg[1:0] == 2'b01))
        else $error("crawl stance numerator lost its rounding term");

    a_half_stance_u: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !s2_crawl_reg && !s2_swing_reg) |-> (s2_u_reg == s2_t_reg))
        else $error("stance parameter differs from doubled phase");

    a_stance_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s4_valid_reg && !s4_swing_reg) |->
        (s4_cpts_reg.x[0] == s4_cpts_reg.x[5] && s4_cpts_reg.y[2] == s4_cpts_reg.y[0]))
        else $error("stance control points are not all equal");

endmodule

`default_nettype wire

[design/gft_bezier.sv]
// De Casteljau evaluation of the six-point arc, one reduction level per register stage.
// Five stages for x, y and z in parallel; depends on gft_pkg.
`default_nettype none

module gft_bezier (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire gft_pkg::cpts_t in_cpts,
    input  wire logic [15:0]    in_t,
    input  wire logic           in_swing,
    output logic                out_valid,
    input  wire logic           out_ready,
    output gft_pkg::pos_t       out_x,
    output gft_pkg::pos_t       out_y,
    output gft_pkg::pos_t       out_z,
    output logic                out_swing
);

    logic [gft_pkg::POS_W-1:0] cur_x [0:4][0:5];
    logic [gft_pkg::POS_W-1:0] cur_y [0:4][0:5];
    logic [gft_pkg::POS_W-1:0] cur_z [0:4][0:5];
    logic [15:0]               cur_t [0:4];
    logic [4:0]                cur_valid;
    logic [4:0]                cur_swing;

    logic [gft_pkg::POS_W-1:0] nx_x [1:5][0:5];
    logic [gft_pkg::POS_W-1:0] nx_y [1:5][0:5];
    logic [gft_pkg::POS_W-1:0] nx_z [1:5][0:5];

    logic [gft_pkg::POS_W-1:0] wx_reg [1:5][0:5];
    logic [gft_pkg::POS_W-1:0] wy_reg [1:5][0:5];
    logic [gft_pkg::POS_W-1:0] wz_reg [1:5][0:5];
    logic [15:0]               t_reg  [1:4];
    logic [5:1]                vld_reg;
    logic [5:1]                swing_reg;
    logic [6:1]                lvl_en;

    assign lvl_en[6] = out_ready;
    assign in_ready  = lvl_en[1];

    for (genvar ln = 0; ln < 6; ln++) begin : g_src
        assign cur_x[0][ln] = in_cpts.x[ln];
        assign cur_y[0][ln] = in_cpts.y[ln];
        assign cur_z[0][ln] = in_cpts.z[ln];
    end
    assign cur_t[0]     = in_t;
    assign cur_valid[0] = in_valid;
    assign cur_swing[0] = in_swing;

    for (genvar lv = 1; lv <= 4; lv++) begin : g_cur
        assign cur_x[lv]     = wx_reg[lv];
        assign cur_y[lv]     = wy_reg[lv];
        assign cur_z[lv]     = wz_reg[lv];
        assign cur_t[lv]     = t_reg[lv];
        assign cur_valid[lv] = vld_reg[lv];
        assign cur_swing[lv] = swing_reg[lv];
    end

    for (genvar lv = 1; lv <= 5; lv++) begin : g_lvl
        assign lvl_en[lv] = !vld_reg[lv] || lvl_en[lv+1];
        for (genvar ln = 0; ln < 6; ln++) begin : g_lane
            if (ln < 6 - lv) begin : g_mix
                assign nx_x[lv][ln] = gft_pkg::lerp(cur_x[lv-1][ln], cur_x[lv-1][ln+1],
                                                    cur_t[lv-1]);
                assign nx_y[lv][ln] = gft_pkg::lerp(cur_y[lv-1][ln], cur_y[lv-1][ln+1],
                                                    cur_t[lv-1]);
                assign nx_z[lv][ln] = gft_pkg::lerp(cur_z[lv-1][ln], cur_z[lv-1][ln+1],
                                                    cur_t[lv-1]);
            end else begin : g_hold
                assign nx_x[lv][ln] = cur_x[lv-1][ln];
                assign nx_y[lv][ln] = cur_y[lv-1][ln];
                assign nx_z[lv][ln] = cur_z[lv-1][ln];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= 5; k++) begin
                if (lvl_en[k]) begin
                    vld_reg[k] <= cur_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= 5; k++) begin
            if (lvl_en[k]) begin
                wx_reg[k]    <= nx_x[k];
                wy_reg[k]    <= nx_y[k];
                wz_reg[k]    <= nx_z[k];
                swing_reg[k] <= cur_swing[k-1];
            end
        end
        for (int k = 1; k <= 4; k++) begin
            if (lvl_en[k]) begin
                t_reg[k] <= cur_t[k-1];
            end
        end
    end

    assign out_valid = vld_reg[5];
    assign out_x     = gft_pkg::pos_t'(wx_reg[5][0]);
    assign out_y     = gft_pkg::pos_t'(wy_reg[5][0]);
    assign out_z     = gft_pkg::pos_t'(wz_reg[5][0]);
    assign out_swing = swing_reg[5];

endmodule

`default_nettype wire

[design/gft_out.sv]
// Output stage: rounds and saturates the foot point and holds the result word.
// One register stage; depends on gft_pkg.
`default_nettype none

module gft_out (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire gft_pkg::pos_t in_x,
    input  wire gft_pkg::pos_t in_y,
    input  wire gft_pkg::pos_t in_z,
    input  wire logic          in_swing,
    output logic               m_valid,
    input  wire logic          m_ready,
    output gft_pkg::out_t      m_data
);

    logic          m_valid_reg;
    gft_pkg::out_t m_data_reg;
    gft_pkg::out_t m_data_next;

    assign in_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_data_next.foot_x   = gft_pkg::to_out(in_x);
        m_data_next.foot_y   = gft_pkg::to_out(in_y);
        m_data_next.foot_z   = gft_pkg::to_out(in_z);
        m_data_next.in_swing = in_swing;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[design/gait_foot_trajectory.sv]
// Top level of the quadruped foot trajectory block: configuration registers and pipeline.
// Instantiates gft_front, gft_bezier and gft_out; depends on gft_pkg.
//
// Usage. Each input word (s_valid/s_ready, s_data) names a leg and carries a gait phase,
// a step vector, a lift height and the neutral foot point. One result word per input
// comes out on m_valid/m_ready/m_data: the foot point and a swing flag, in input order.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the gait
// type (index 0) and the overshoot fraction (index 1); it is always ready, and other
// indexes are ignored. Write it only while no word is in flight.
// Words pass from input acceptance to m_valid through four front stages (phase,
// divide and multiply steps, control points), five arc reduction stages and the output
// register. One word can enter every cycle; throughput is one word per cycle.
// Each stage holds its word while the stage after it is full and stalled, so a stalled
// receiver fills empty slots first and then holds s_ready low; nothing is lost.
// A synchronous low on aresetn empties the pipeline and restores trot gait and an
// overshoot of 13107/65536.
`default_nettype none

module gait_foot_trajectory (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gft_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output gft_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    logic [1:0]     gait_type_reg;
    logic [15:0]    curve_delta_reg;

    logic           fr_valid;
    logic           fr_ready;
    gft_pkg::cpts_t fr_cpts;
    logic [15:0]    fr_t;
    logic           fr_swing;

    logic           bz_valid;
    logic           bz_ready;
    gft_pkg::pos_t  bz_x;
    gft_pkg::pos_t  bz_y;
    gft_pkg::pos_t  bz_z;
    logic           bz_swing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gait_type_reg   <= gft_pkg::GAIT_TYPE_RST;
            curve_delta_reg <= gft_pkg::CURVE_DELTA_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                gft_pkg::REG_GAIT_TYPE:   gait_type_reg   <= cfg_data[1:0];
                gft_pkg::REG_CURVE_DELTA: curve_delta_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    gft_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .gait_type   (gait_type_reg),
        .curve_delta (curve_delta_reg),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_cpts    (fr_cpts),
        .out_t       (fr_t),
        .out_swing   (fr_swing)
    );

    gft_bezier u_bezier (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cpts   (fr_cpts),
        .in_t      (fr_t),
        .in_swing  (fr_swing),
        .out_valid (bz_valid),
        .out_ready (bz_ready),
        .out_x     (bz_x),
        .out_y     (bz_y),
        .out_z     (bz_z),
        .out_swing (bz_swing)
    );

    gft_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (bz_valid),
        .in_ready (bz_ready),
        .in_x     (bz_x),
        .in_y     (bz_y),
        .in_z     (bz_z),
        .in_swing (bz_swing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
